>>> hdl/oqkr_pkg.sv
// ----------------------------------------------------------------------------
// oqkr_pkg
// Shared codes and control types for the ordered queue with keyed removal.
// ----------------------------------------------------------------------------
package oqkr_pkg;

   // Operation codes carried in req_tuser
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Result status codes carried in rsp_tuser
   localparam logic [2:0] STAT_APPENDED  = 3'd0;
   localparam logic [2:0] STAT_FULL      = 3'd1;
   localparam logic [2:0] STAT_REMOVED   = 3'd2;
   localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
   localparam logic [2:0] STAT_EMPTY     = 3'd4;

   // Field widths of one result item
   localparam int STATUS_W   = 3;
   localparam int POSITION_W = 5;
   localparam int OCCUPY_W   = 5;
   localparam int ID_W       = 16;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // register operation, key and slot match vector
      logic commit;    // update the queue and load the result register
   } oqkr_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;  // result register can take a new item this cycle
   } oqkr_stat_type;

endpackage

>>> hdl/oqkr_ctrl.sv
// ----------------------------------------------------------------------------
// oqkr_ctrl
// Sequencer: takes an item, then commits it once the result register frees.
// ----------------------------------------------------------------------------
module oqkr_ctrl
   import oqkr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  oqkr_stat_type dp_stat,
   output oqkr_cmd_type  dp_cmd
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_COMMIT = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      dp_cmd.capture = 1'b0;
      dp_cmd.commit  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready     = 1'b1;
            dp_cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (dp_stat.out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hdl/oqkr_dp.sv
// ----------------------------------------------------------------------------
// oqkr_dp
// Slot row with per-slot key compare, close-up shift, fill count and result
// register.
// ----------------------------------------------------------------------------
module oqkr_dp
   import oqkr_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  oqkr_cmd_type          dp_cmd,
   output oqkr_stat_type         dp_stat,
   input  logic                  req_cmd,
   input  logic [ID_W-1:0]       req_id,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [POSITION_W-1:0] rsp_position,
   output logic [OCCUPY_W-1:0]   rsp_occupancy
);

   localparam int FW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [FW-1:0] CAP_COUNT = FW'(CAPACITY);

   logic [ID_W-1:0]     slots_ff [CAPACITY];
   logic [FW-1:0]       fill_ff;
   logic [FW-1:0]       fill_in;
   logic                op_ff;
   logic [ID_W-1:0]     key_ff;
   logic [CAPACITY-1:0] match_ff;
   logic [CAPACITY-1:0] match_in;
   logic [CAPACITY-1:0] shift_mask;
   logic [IW-1:0]       hit_idx;
   logic [FW-1:0]       hit_pos;
   logic                hit_any;
   logic                do_append;
   logic                do_remove;
   logic [STATUS_W-1:0] status_in;
   logic [FW-1:0]       pos_in;

   logic                  out_valid_ff;
   logic [STATUS_W-1:0]   out_status_ff;
   logic [POSITION_W-1:0] out_pos_ff;
   logic [OCCUPY_W-1:0]   out_occ_ff;

   // Compare the incoming key with every held slot
   always_comb begin
      for (int j = 0; j < CAPACITY; j++) begin
         match_in[j] = (slots_ff[j] == req_id) && (FW'(j) < fill_ff);
      end
   end

   // Locate the first hit; slots from it to the tail move up one place
   assign hit_any    = |match_ff;
   assign shift_mask = match_ff | (~match_ff + 1'b1);

   always_comb begin
      hit_idx = '0;
      for (int j = CAPACITY - 1; j >= 0; j--) begin
         if (match_ff[j]) begin
            hit_idx = IW'(j);
         end
      end
   end

   assign hit_pos = FW'(hit_idx) + 1'b1;

   // Decide the outcome of the held operation
   always_comb begin
      do_append = 1'b0;
      do_remove = 1'b0;
      pos_in    = '0;
      fill_in   = fill_ff;
      if (op_ff == CMD_APPEND) begin
         if (fill_ff < CAP_COUNT) begin
            do_append = 1'b1;
            fill_in   = fill_ff + 1'b1;
            status_in = STAT_APPENDED;
         end else begin
            status_in = STAT_FULL;
         end
      end else if (fill_ff == '0) begin
         status_in = STAT_EMPTY;
      end else if (hit_any) begin
         do_remove = 1'b1;
         fill_in   = fill_ff - 1'b1;
         pos_in    = hit_pos;
         status_in = STAT_REMOVED;
      end else begin
         status_in = STAT_NOT_FOUND;
      end
   end

   // Hold the operation and its match vector
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         op_ff    <= req_cmd;
         key_ff   <= req_id;
         match_ff <= match_in;
      end
   end

   // Append at the tail or close up behind the removed slot
   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         for (int j = 0; j < CAPACITY; j++) begin
            if (do_append && (FW'(j) == fill_ff)) begin
               slots_ff[j] <= key_ff;
            end else if (do_remove && shift_mask[j] && (j < CAPACITY - 1)) begin
               slots_ff[j] <= slots_ff[(j < CAPACITY - 1) ? j + 1 : j];
            end
         end
      end
   end

   // Fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (dp_cmd.commit) begin
         fill_ff <= fill_in;
      end
   end

   // Result register: load on commit, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (dp_cmd.commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         out_status_ff <= status_in;
         out_pos_ff    <= POSITION_W'(pos_in);
         out_occ_ff    <= OCCUPY_W'(fill_in);
      end
   end

   assign dp_stat.out_free = !out_valid_ff || rsp_ready;
   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_position     = out_pos_ff;
   assign rsp_occupancy    = out_occ_ff;

endmodule

>>> hdl/ordered_queue_keyed_removal.sv
// ----------------------------------------------------------------------------
// ordered_queue_keyed_removal
// Bounded ordered queue of 16-bit ids with append and remove-first-match.
// ----------------------------------------------------------------------------
// Each request item is an append (tuser 0) or a remove (tuser 1) of the id in
// tdata, and yields exactly one result item: status in rsp_tuser, position
// and occupancy in rsp_tdata. In the accept cycle the key is compared against
// every held slot at once and the match vector is registered; in the commit
// state the queue is updated (tail write, or the slots behind the first match
// move up one place) and the result register is loaded. That update waits
// while the previous result has not been taken, and a new item is accepted
// only after the update. No clearing pass after reset is needed: only the
// fill count, the result valid flag and the sequencer state are cleared.
// ----------------------------------------------------------------------------
module ordered_queue_keyed_removal
   import oqkr_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] item_id
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [4:0] position, [9:5] occupancy, [15:10] zero
   output logic [2:0]  rsp_tuser    // [2:0] status
);

   oqkr_cmd_type          dp_cmd;
   oqkr_stat_type         dp_stat;
   logic [POSITION_W-1:0] rsp_position;
   logic [OCCUPY_W-1:0]   rsp_occupancy;

   // Sequencer
   oqkr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd)
   );

   // Slot row and result register
   oqkr_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .dp_cmd        (dp_cmd),
      .dp_stat       (dp_stat),
      .req_cmd       (req_tuser),
      .req_id        (req_tdata),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status    (rsp_tuser),
      .rsp_position  (rsp_position),
      .rsp_occupancy (rsp_occupancy)
   );

   // Pack the result fields
   assign rsp_tdata = {6'd0, rsp_occupancy, rsp_position};

endmodule
